// ----- sv/tpsd_pkg.sv -----
// Types and constants shared by the pixel stream decoder modules.
`default_nettype none
package tpsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_PIXEL_DEPTH      = 2'd0;
    localparam logic [1:0] CFG_RUN_LENGTH_CODED = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH      = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT     = 2'd3;

    localparam logic [1:0] DEPTH_INDEX8  = 2'd0;
    localparam logic [1:0] DEPTH_RGB555  = 2'd1;

    localparam logic [15:0] MIN_WIDTH = 16'd4;

    typedef struct packed {
        logic [1:0]  pixel_depth;
        logic        run_length_coded;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_cfg;

    // One decoded pixel with its repeat count, as handed to the segment stage.
    typedef struct packed {
        logic [7:0] val0;
        logic [7:0] val1;
        logic [7:0] val2;
        logic [7:0] count;
        logic       restart;
    } t_job;

endpackage
`default_nettype wire

// ----- sv/tpsd_front.sv -----
// Front end: packet header parsing and pixel assembly from incoming bytes.
`default_nettype none
module tpsd_front
    import tpsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_start,
    input  wire logic       i_q_ready,
    output logic            o_push,
    output t_job            o_job
);

    logic        r_in_packet, n_in_packet;
    logic [7:0]  r_rem, n_rem;
    logic        r_run, n_run;
    logic [1:0]  r_bip, n_bip;
    logic [23:0] r_gat, n_gat;
    logic        r_pend, n_pend;

    logic        e_in_packet;
    logic [7:0]  e_rem;
    logic        e_run;
    logic [1:0]  e_bip;
    logic [23:0] e_gat;
    logic        e_pend;
    logic [23:0] gat_add;
    logic [7:0]  rem_dec;
    logic        accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        // A frame start clears the packet and pixel state before the word is used.
        e_in_packet = r_in_packet;
        e_rem       = r_rem;
        e_run       = r_run;
        e_bip       = r_bip;
        e_gat       = r_gat;
        e_pend      = r_pend;
        if (i_frame_start) begin
            e_in_packet = 1'b0;
            e_rem       = 8'd0;
            e_run       = 1'b0;
            e_bip       = 2'd0;
            e_gat       = 24'd0;
            e_pend      = 1'b1;
        end

        case (e_bip)
            2'd0:    gat_add = e_gat | {16'd0, i_data_byte};
            2'd1:    gat_add = e_gat | {8'd0, i_data_byte, 8'd0};
            2'd2:    gat_add = e_gat | {i_data_byte, 16'd0};
            default: gat_add = e_gat;
        endcase
        rem_dec = (e_rem != 8'd0) ? e_rem - 8'd1 : 8'd0;

        n_in_packet = r_in_packet;
        n_rem       = r_rem;
        n_run       = r_run;
        n_bip       = r_bip;
        n_gat       = r_gat;
        n_pend      = r_pend;
        o_push      = 1'b0;
        o_job       = '0;

        if (accept) begin
            n_in_packet = e_in_packet;
            n_rem       = e_rem;
            n_run       = e_run;
            n_bip       = e_bip;
            n_gat       = e_gat;
            n_pend      = e_pend;
            if (i_cfg.run_length_coded && !e_in_packet) begin
                n_run       = i_data_byte[7];
                n_rem       = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_in_packet = 1'b1;
                n_bip       = 2'd0;
                n_gat       = 24'd0;
            end else if (e_bip < i_cfg.pixel_depth) begin
                n_bip = e_bip + 2'd1;
                n_gat = gat_add;
            end else begin
                n_bip = 2'd0;
                n_gat = 24'd0;
                case (i_cfg.pixel_depth)
                    DEPTH_INDEX8: begin
                        o_job.val0 = gat_add[7:0];
                        o_job.val1 = 8'd0;
                        o_job.val2 = 8'd0;
                    end
                    DEPTH_RGB555: begin
                        o_job.val0 = {gat_add[14:10], 3'b000};
                        o_job.val1 = {gat_add[9:5], 3'b000};
                        o_job.val2 = {gat_add[4:0], 3'b000};
                    end
                    default: begin
                        o_job.val0 = gat_add[7:0];
                        o_job.val1 = gat_add[15:8];
                        o_job.val2 = gat_add[23:16];
                    end
                endcase
                if (!i_cfg.run_length_coded) begin
                    o_job.count = 8'd1;
                end else if (e_run) begin
                    o_job.count = (e_rem == 8'd0) ? 8'd1 : e_rem;
                    n_rem       = 8'd0;
                    n_in_packet = 1'b0;
                end else begin
                    o_job.count = 8'd1;
                    n_rem       = rem_dec;
                    n_in_packet = (rem_dec != 8'd0);
                end
                o_job.restart = e_pend;
                n_pend        = 1'b0;
                o_push        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_rem       <= 8'd0;
            r_run       <= 1'b0;
            r_bip       <= 2'd0;
            r_gat       <= 24'd0;
            r_pend      <= 1'b0;
        end else begin
            r_in_packet <= n_in_packet;
            r_rem       <= n_rem;
            r_run       <= n_run;
            r_bip       <= n_bip;
            r_gat       <= n_gat;
            r_pend      <= n_pend;
        end
    end

endmodule
`default_nettype wire

// ----- sv/tpsd_queue.sv -----
// Short first-in first-out queue of decoded pixels between front and back end.
`default_nettype none
module tpsd_queue
    import tpsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;
    logic                   do_push, do_pop;

    assign o_ready = (r_count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QUEUE_PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- sv/tpsd_back.sv -----
// Back end: splits each pixel run into row-clipped segments and tracks position.
`default_nettype none
module tpsd_back
    import tpsd_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_q_valid,
    input  wire t_job                  i_q_job,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_first_byte,
    output logic [7:0]                 o_second_byte,
    output logic [7:0]                 o_third_byte,
    output logic [7:0]                 o_repeat_count,
    output logic [COORD_BITS-1:0]      o_row_index,
    output logic [COORD_BITS-1:0]      o_column_start,
    output logic                       o_row_end,
    output logic                       o_image_done,
    output logic                       o_last_of_item
);

    logic                  r_busy, n_busy;
    logic [7:0]            r_v0, n_v0, r_v1, n_v1, r_v2, n_v2;
    logic [7:0]            r_cnt, n_cnt;
    logic [15:0]           r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic                  r_finished, n_finished;

    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_o0, n_o0, r_o1, n_o1, r_o2, n_o2, r_ocnt, n_ocnt;
    logic [COORD_BITS-1:0] r_orow, n_orow, r_ocol, n_ocol;
    logic                  r_orend, n_orend, r_odone, n_odone, r_olast, n_olast;

    logic [15:0]           eff_width;
    logic                  col_lt;
    logic [15:0]           avail;
    logic [7:0]            take;
    logic                  rend;
    logic [COORD_BITS-1:0] row_next;
    logic                  done;
    logic                  seg_last;
    logic                  out_adv;
    logic                  free;
    logic                  emit;
    logic                  load;

    always_comb begin
        eff_width = (i_cfg.image_width < MIN_WIDTH) ? MIN_WIDTH : i_cfg.image_width;
        col_lt    = (r_col < eff_width);
        avail     = eff_width - r_col;
        // A column at or past the width (width lowered mid-row) closes the row
        // with a single pixel.
        if (!col_lt) begin
            take = 8'd1;
        end else if (avail > {8'd0, r_cnt}) begin
            take = r_cnt;
        end else begin
            take = avail[7:0];
        end
        rend     = !col_lt || ({8'd0, r_cnt} >= avail);
        row_next = r_row + COORD_BITS'(1);
        done     = rend && (17'(row_next) >= 17'(i_cfg.image_height));
        seg_last = (take == r_cnt) || done;
    end

    always_comb begin
        n_busy      = r_busy;
        n_v0        = r_v0;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_finished  = r_finished;
        n_out_valid = r_out_valid;
        n_o0        = r_o0;
        n_o1        = r_o1;
        n_o2        = r_o2;
        n_ocnt      = r_ocnt;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        n_orend     = r_orend;
        n_odone     = r_odone;
        n_olast     = r_olast;

        out_adv = !r_out_valid || i_ready;
        free    = !r_busy;
        emit    = 1'b0;

        if (r_busy) begin
            if (r_finished) begin
                // Pixels after the last row are dropped until a new frame.
                free = 1'b1;
            end else if (out_adv) begin
                emit        = 1'b1;
                n_out_valid = 1'b1;
                n_o0        = r_v0;
                n_o1        = r_v1;
                n_o2        = r_v2;
                n_ocnt      = take;
                n_orow      = r_row;
                n_ocol      = r_col[COORD_BITS-1:0];
                n_orend     = rend;
                n_odone     = done;
                n_olast     = seg_last;
                if (rend) begin
                    n_col = 16'd0;
                    n_row = row_next;
                end else begin
                    n_col = r_col + {8'd0, take};
                end
                n_finished = done;
                if (seg_last) begin
                    free = 1'b1;
                end else begin
                    n_cnt = r_cnt - take;
                end
            end
        end

        if (out_adv && !emit) begin
            n_out_valid = 1'b0;
        end

        load = free && i_q_valid;
        if (load) begin
            n_busy = 1'b1;
            n_v0   = i_q_job.val0;
            n_v1   = i_q_job.val1;
            n_v2   = i_q_job.val2;
            n_cnt  = i_q_job.count;
            if (i_q_job.restart) begin
                n_col      = 16'd0;
                n_row      = '0;
                n_finished = 1'b0;
            end
        end else if (free) begin
            n_busy = 1'b0;
        end
    end

    assign o_q_pop        = load;
    assign o_valid        = r_out_valid;
    assign o_first_byte   = r_o0;
    assign o_second_byte  = r_o1;
    assign o_third_byte   = r_o2;
    assign o_repeat_count = r_ocnt;
    assign o_row_index    = r_orow;
    assign o_column_start = r_ocol;
    assign o_row_end      = r_orend;
    assign o_image_done   = r_odone;
    assign o_last_of_item = r_olast;

    always_ff @(posedge i_clk) begin
        r_v0   <= n_v0;
        r_v1   <= n_v1;
        r_v2   <= n_v2;
        r_cnt  <= n_cnt;
        r_o0   <= n_o0;
        r_o1   <= n_o1;
        r_o2   <= n_o2;
        r_ocnt <= n_ocnt;
        r_orow <= n_orow;
        r_ocol <= n_ocol;
        r_orend <= n_orend;
        r_odone <= n_odone;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_col       <= 16'd0;
            r_row       <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_col       <= n_col;
            r_row       <= n_row;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- sv/tga_pixel_stream_decoder_unit.sv -----
// Throughput: one input word per cycle while the pixel queue has room; the
// segment stage emits one segment per cycle while the output is taken, so a
// run spread over k rows gives k segments, and the pixel queue absorbs up to
// four pixels before the input stalls.
// Reset: synchronous, active low; registers return to 24-bit, coded, 640 x 480.
`default_nettype none
module tga_pixel_stream_decoder_unit
    import tpsd_pkg::*;
#(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_first_byte,
    output logic [7:0]                 o_second_byte,
    output logic [7:0]                 o_third_byte,
    output logic [7:0]                 o_repeat_count,
    output logic [COORD_BITS-1:0]      o_row_index,
    output logic [COORD_BITS-1:0]      o_column_start,
    output logic                       o_row_end,
    output logic                       o_image_done,
    output logic                       o_last_of_item
);

    t_cfg r_cfg, n_cfg;
    logic q_ready;
    logic q_push;
    t_job push_job;
    logic q_valid;
    t_job head_job;
    logic q_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_DEPTH:      n_cfg.pixel_depth      = i_cfg_data[1:0];
                CFG_RUN_LENGTH_CODED: n_cfg.run_length_coded = i_cfg_data[0];
                CFG_IMAGE_WIDTH:      n_cfg.image_width      = i_cfg_data;
                CFG_IMAGE_HEIGHT:     n_cfg.image_height     = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_depth      <= 2'd2;
            r_cfg.run_length_coded <= 1'b1;
            r_cfg.image_width      <= 16'd640;
            r_cfg.image_height     <= 16'd480;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tpsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_q_ready     (q_ready),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    tpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    tpsd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_job        (head_job),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_first_byte   (o_first_byte),
        .o_second_byte  (o_second_byte),
        .o_third_byte   (o_third_byte),
        .o_repeat_count (o_repeat_count),
        .o_row_index    (o_row_index),
        .o_column_start (o_column_start),
        .o_row_end      (o_row_end),
        .o_image_done   (o_image_done),
        .o_last_of_item (o_last_of_item)
    );

endmodule
`default_nettype wire

// ----- sv/tpsd_checker.sv -----
// Port-level checks on the decoder's segment output, bound to the top level.
`default_nettype none
module tpsd_checker #(
    parameter int unsigned COORD_BITS = 16
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [7:0]            o_first_byte,
    input wire logic [7:0]            o_repeat_count,
    input wire logic [COORD_BITS-1:0] o_column_start,
    input wire logic                  o_row_end,
    input wire logic                  o_image_done,
    input wire logic                  o_last_of_item
);

    // A waiting word's first byte, length and column must not change until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_first_byte)
            && $stable(o_repeat_count) && $stable(o_column_start))
        else $error("output word changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_repeat_count != 8'd0) && (o_repeat_count <= 8'd128))
        else $error("segment length out of range");

    // Finishing the image always closes a row and ends the word's segments.
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_row_end && o_last_of_item)
        else $error("image end without row end or last flag");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

endmodule

bind tga_pixel_stream_decoder_unit tpsd_checker #(
    .COORD_BITS (COORD_BITS)
) u_tpsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_first_byte   (o_first_byte),
    .o_repeat_count (o_repeat_count),
    .o_column_start (o_column_start),
    .o_row_end      (o_row_end),
    .o_image_done   (o_image_done),
    .o_last_of_item (o_last_of_item)
);
`default_nettype wire
